// ===== src/tsvs_pkg.sv =====
// shared types and character constants of the tsv line field splitter
package tsvs_pkg;

  // character codes
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_N   = 8'h6E;
  localparam logic [7:0] CH_R   = 8'h72;
  localparam logic [7:0] CH_T   = 8'h74;

  // delimiter after reset
  localparam logic [7:0] DELIM_RESET = CH_TAB;

  // result kind
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_SEP  = 2'd1,
    KIND_EOR  = 2'd2,
    KIND_ERR  = 2'd3
  } kind_e;

  // classified work for the back end
  // pair set: a backslash data result, then data_byte as data
  // pair clear: one result of kind with data_byte
  typedef struct packed {
    logic       pair;
    kind_e      kind;
    logic [7:0] data_byte;
  } op_t;

endpackage

// ===== src/tsvs_front.sv =====
// front end: accepts input items, tracks escape and skip state, classifies
module tsvs_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_byte_i,
  input  logic             in_eol_i,
  input  logic [7:0]       delimiter_i,
  input  logic             q_full_i,
  output logic             push_o,
  output tsvs_pkg::op_t    push_op_o
);

  logic escape_q, escape_d;
  logic skip_q, skip_d;
  logic accept;
  logic emit;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    escape_d            = escape_q;
    skip_d              = skip_q;
    emit                = 1'b0;
    push_op_o.pair      = 1'b0;
    push_op_o.kind      = tsvs_pkg::KIND_DATA;
    push_op_o.data_byte = in_byte_i;
    if (in_eol_i) begin
      // dangling backslash goes out as plain data
      if (escape_q && !skip_q) begin
        emit                = 1'b1;
        push_op_o.data_byte = tsvs_pkg::CH_BSL;
      end
      escape_d = 1'b0;
      skip_d   = 1'b0;
    end else if (skip_q) begin
      emit = 1'b0;
    end else if (escape_q) begin
      escape_d = 1'b0;
      emit     = 1'b1;
      case (in_byte_i)
        tsvs_pkg::CH_N:   push_op_o.data_byte = tsvs_pkg::CH_LF;
        tsvs_pkg::CH_R:   push_op_o.data_byte = tsvs_pkg::CH_CR;
        tsvs_pkg::CH_T:   push_op_o.data_byte = tsvs_pkg::CH_TAB;
        tsvs_pkg::CH_BSL: push_op_o.data_byte = tsvs_pkg::CH_BSL;
        tsvs_pkg::CH_TAB: begin
          push_op_o.kind      = tsvs_pkg::KIND_ERR;
          push_op_o.data_byte = 8'h00;
          skip_d              = 1'b1;
        end
        default: push_op_o.pair = 1'b1;
      endcase
    end else if (in_byte_i == delimiter_i) begin
      emit                = 1'b1;
      push_op_o.kind      = tsvs_pkg::KIND_SEP;
      push_op_o.data_byte = 8'h00;
    end else if (in_byte_i inside {tsvs_pkg::CH_LF, tsvs_pkg::CH_CR}) begin
      emit                = 1'b1;
      push_op_o.kind      = tsvs_pkg::KIND_EOR;
      push_op_o.data_byte = 8'h00;
      skip_d              = 1'b1;
    end else if (in_byte_i == tsvs_pkg::CH_BSL) begin
      escape_d = 1'b1;
    end else begin
      emit = 1'b1;
    end
  end

  assign push_o = accept && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      escape_q <= 1'b0;
      skip_q   <= 1'b0;
    end else if (accept) begin
      escape_q <= escape_d;
      skip_q   <= skip_d;
    end
  end

endmodule

// ===== src/tsvs_queue.sv =====
// short fifo of classified items between front and back end
module tsvs_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tsvs_pkg::op_t push_op_i,
  output logic          full_o,
  output logic          valid_o,
  output tsvs_pkg::op_t head_o,
  input  logic          pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tsvs_pkg::op_t       mem_q [Depth];
  logic [PtrW-1:0]     wptr_q, wptr_d;
  logic [PtrW-1:0]     rptr_q, rptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_op_i;
    end
  end

endmodule

// ===== src/tsvs_back.sv =====
// back end: expands queued items into results behind an output register
module tsvs_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  tsvs_pkg::op_t         q_head_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_byte_o,
  output tsvs_pkg::kind_e       out_kind_o,
  output logic                  out_last_o
);

  logic            valid_q, valid_d;
  logic [7:0]      byte_q, byte_d;
  tsvs_pkg::kind_e kind_q, kind_d;
  logic            last_q, last_d;
  logic            half_q, half_d;
  logic            load;

  assign load = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    kind_d  = kind_q;
    last_d  = last_q;
    half_d  = half_q;
    q_pop_o = 1'b0;
    if (load) begin
      valid_d = q_valid_i;
      if (q_valid_i) begin
        if (q_head_i.pair && !half_q) begin
          // leading backslash of a passed-through escape
          byte_d = tsvs_pkg::CH_BSL;
          kind_d = tsvs_pkg::KIND_DATA;
          last_d = 1'b0;
          half_d = 1'b1;
        end else begin
          byte_d  = q_head_i.data_byte;
          kind_d  = q_head_i.kind;
          last_d  = 1'b1;
          half_d  = 1'b0;
          q_pop_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      half_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      half_q  <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    kind_q <= kind_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_kind_o  = kind_q;
  assign out_last_o  = last_q;

endmodule

// ===== src/tsv_line_field_splitter_unit.sv =====
// top level of the tsv line field splitter
// Splits a line of linear-tsv text into fields. Bytes enter one item per
// cycle on the slave stream (tdata = byte, tlast = end of line). Each item
// gives zero, one or two results on the master stream: tdata is the
// unescaped byte (zero unless the kind is data), tuser the kind (data,
// field separator, end of record, backslash-tab error) and tlast marks the
// final result of an input item. A front end classifies each item in the
// cycle it is accepted and holds the escape and skip flags; a small queue
// (QueueDepth entries) carries the classified items to a back end that
// expands them behind an output register. Input is taken every cycle while
// the queue has room; the back end issues one result per cycle while the
// output is ready, so an escape passed through unchanged (two results)
// holds it longer and the queue absorbs that. The delimiter register
// (reset value tab) is written through the cfg channel, which is always
// ready; write it only while the block is idle.
module tsv_line_field_splitter_unit #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // end_of_line
  // result stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser,   // [1:0] kind
  output logic       m_axis_tlast,   // last_of_run
  // delimiter write channel
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  logic [7:0]      delimiter_q;
  logic            q_full;
  logic            push;
  tsvs_pkg::op_t   push_op;
  logic            q_valid;
  tsvs_pkg::op_t   q_head;
  logic            q_pop;
  tsvs_pkg::kind_e out_kind;

  // delimiter register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delimiter_q <= tsvs_pkg::DELIM_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      delimiter_q <= cfg_data_i;
    end
  end

  // classify and track line state
  tsvs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_eol_i    (s_axis_tlast),
    .delimiter_i (delimiter_q),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_op_o   (push_op)
  );

  // decoupling queue
  tsvs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .full_o    (q_full),
    .valid_o   (q_valid),
    .head_o    (q_head),
    .pop_i     (q_pop)
  );

  // result expansion and output register
  tsvs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_kind_o  (out_kind),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tuser = out_kind;

  // the queue only grows on an accepted input item
  a_push_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (s_axis_tvalid && s_axis_tready))
    else $error("queue push without input accept");

  // a result that is not the last of its run is always the escape backslash
  a_first_of_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |->
      (m_axis_tuser == tsvs_pkg::KIND_DATA && m_axis_tdata == tsvs_pkg::CH_BSL))
    else $error("non-final result is not a backslash");

  // the second result of a pair follows right after the first is taken
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("second result of pair missing");

  // separators, end of record and errors carry a zero byte
  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != tsvs_pkg::KIND_DATA) |-> (m_axis_tdata == 8'h00))
    else $error("non-data result with nonzero byte");

endmodule
